@@ rtl/bubble_sort_and_search_core_defines.svh @@
// Assertion macros for the bubble sort and search core.
// Included by the top level only; depends on nothing else.
`ifndef BUBBLE_SORT_AND_SEARCH_CORE_DEFINES_SVH
`define BUBBLE_SORT_AND_SEARCH_CORE_DEFINES_SVH

// Same-cycle check: when the antecedent holds, the consequent holds too.
`define BSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bubble sort core: same-cycle check failed");

// Next-cycle check: when the antecedent holds, the consequent holds in the next cycle.
`define BSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bubble sort core: next-cycle check failed");

`endif

@@ rtl/bss_pkg.sv @@
// Shared types and constants of the bubble sort and search core.
// Used by bubble_sort_and_search_core; depends on nothing.
`default_nettype none

package bss_pkg;

    // Default sizes of the element store.
    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths of the stream words.
    localparam int VAL_W       = 32;
    localparam int IDX_W       = 5;
    localparam int OUT_TDATA_W = 40;
    localparam int MAX_RESULTS = 32;

    // Request selector on the input stream.
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // Result kind on the output stream.
    localparam logic KIND_SORTED = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_PASS_START,
        S_PASS_FIRST,
        S_PASS_RUN,
        S_PASS_END,
        S_EMIT_RD,
        S_EMIT_WAIT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_ANSWER
    } t_state;

endpackage

`default_nettype wire

@@ rtl/bubble_sort_and_search_core.sv @@
// Bubble sort and search core built around one synchronous element memory.
// Depends on bss_pkg and bubble_sort_and_search_core_defines.svh.
// A load or search word is taken while the core is idle; a load
// marked last closes the set, sorts it in place and streams the sorted words out.
// Sorting runs in passes; every pass walks the memory through its single read
// port, one element per cycle, with a turnaround state at each end of a pass.
// Emission reads each sorted word and waits for the sink to take it. A search
// walks the stored elements, reading and comparing each, up to the first match.
// Input is refused while a sort, an emission or a search is under way.
`default_nettype none
`include "bubble_sort_and_search_core_defines.svh"

module bubble_sort_and_search_core #(
    parameter int DEPTH      = bss_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bss_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Input stream.
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: value[31:0].
    input  wire logic [bss_pkg::VAL_W-1:0]       s_axis_tdata,
    // tuser: req_type[0].
    input  wire logic                            s_axis_tuser,
    input  wire logic                            s_axis_tlast,
    // Output stream.
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // tdata: value_res[31:0], index[36:32], found[37], overflow[38], zero[39].
    output logic [bss_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: kind[0].
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Element memory.
    logic signed [DATA_WIDTH-1:0] mem [DEPTH];
    logic signed [DATA_WIDTH-1:0] r_rd_data;
    logic                         mem_we;
    logic [AW-1:0]                mem_wa;
    logic [AW-1:0]                mem_ra;
    logic signed [DATA_WIDTH-1:0] mem_wd;

    // Control state.
    bss_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_closed, n_closed;
    logic            r_dropped, n_dropped;
    logic            r_out_valid, n_out_valid;

    // Working registers.
    logic [AW-1:0]                r_j, n_j;
    logic [AW-1:0]                r_pass, n_pass;
    logic signed [DATA_WIDTH-1:0] r_carry, n_carry;
    logic signed [DATA_WIDTH-1:0] r_key, n_key;
    logic                         r_hit, n_hit;
    logic [AW-1:0]                r_pos, n_pos;

    // Output register fields.
    logic                          r_o_kind, n_o_kind;
    logic [bss_pkg::VAL_W-1:0]     r_o_value, n_o_value;
    logic [bss_pkg::IDX_W-1:0]     r_o_index, n_o_index;
    logic                          r_o_found, n_o_found;
    logic                          r_o_ovf, n_o_ovf;
    logic                          r_o_last, n_o_last;
    logic                          out_load;

    // Derived conditions.
    logic                         in_acc;
    logic                         out_free;
    logic signed [DATA_WIDTH-1:0] in_val;
    logic [CW-1:0]                cnt_base;
    logic                         drop_base;
    logic                         has_room;
    logic [CW-1:0]                load_cnt;
    logic [CW-1:0]                emit_last;
    logic                         run_end;
    logic                         pass_done;
    logic                         emit_end;
    logic                         gt;
    logic                         key_hit;

    // Conditions watched by the assertions.
    logic                         close_acc;
    logic                         srch_acc;
    logic                         answer_out;
    logic                         answer_ok;
    logic                         count_ok;

    assign s_axis_tready = (r_state == bss_pkg::S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign in_val        = DATA_WIDTH'($signed(s_axis_tdata));

    // A load after a closed set starts a fresh one.
    assign cnt_base  = r_closed ? '0 : r_count;
    assign drop_base = r_closed ? 1'b0 : r_dropped;
    assign has_room  = (cnt_base < CW'(DEPTH));
    assign load_cnt  = has_room ? (cnt_base + CW'(1)) : cnt_base;

    // Loop end conditions of the sequencer.
    assign emit_last = (int'(r_count) > bss_pkg::MAX_RESULTS) ?
                       CW'(bss_pkg::MAX_RESULTS - 1) : (r_count - CW'(1));
    assign run_end   = (CW'(r_j) == (r_count - CW'(1)));
    assign pass_done = (CW'(r_pass) == (r_count - CW'(2)));
    assign emit_end  = (CW'(r_j) == emit_last);
    assign gt        = (r_carry > r_rd_data);
    assign key_hit   = (r_rd_data == r_key);

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bss_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser == bss_pkg::REQ_SEARCH) begin
                        n_state = (r_count == '0) ? bss_pkg::S_ANSWER : bss_pkg::S_SRCH_RD;
                    end else if (s_axis_tlast) begin
                        n_state = (load_cnt >= CW'(2)) ? bss_pkg::S_PASS_START
                                                       : bss_pkg::S_EMIT_RD;
                    end
                end
            end
            bss_pkg::S_PASS_START: n_state = bss_pkg::S_PASS_FIRST;
            bss_pkg::S_PASS_FIRST: n_state = bss_pkg::S_PASS_RUN;
            bss_pkg::S_PASS_RUN: begin
                if (run_end) begin
                    n_state = bss_pkg::S_PASS_END;
                end
            end
            bss_pkg::S_PASS_END: begin
                n_state = pass_done ? bss_pkg::S_EMIT_RD : bss_pkg::S_PASS_START;
            end
            bss_pkg::S_EMIT_RD: n_state = bss_pkg::S_EMIT_WAIT;
            bss_pkg::S_EMIT_WAIT: begin
                if (out_free) begin
                    n_state = emit_end ? bss_pkg::S_IDLE : bss_pkg::S_EMIT_RD;
                end
            end
            bss_pkg::S_SRCH_RD: n_state = bss_pkg::S_SRCH_CMP;
            bss_pkg::S_SRCH_CMP: begin
                // Each further element needs its own memory read.
                n_state = (key_hit || run_end) ? bss_pkg::S_ANSWER : bss_pkg::S_SRCH_RD;
            end
            bss_pkg::S_ANSWER: begin
                if (out_free) begin
                    n_state = bss_pkg::S_IDLE;
                end
            end
            default: n_state = bss_pkg::S_IDLE;
        endcase
    end

    // Datapath and output control of the sequencer.
    always_comb begin
        mem_we    = 1'b0;
        mem_wa    = r_j;
        mem_wd    = r_carry;
        mem_ra    = r_j;
        n_count   = r_count;
        n_closed  = r_closed;
        n_dropped = r_dropped;
        n_j       = r_j;
        n_pass    = r_pass;
        n_carry   = r_carry;
        n_key     = r_key;
        n_hit     = r_hit;
        n_pos     = r_pos;
        out_load  = 1'b0;
        n_o_kind  = r_o_kind;
        n_o_value = r_o_value;
        n_o_index = r_o_index;
        n_o_found = r_o_found;
        n_o_ovf   = r_o_ovf;
        n_o_last  = r_o_last;
        unique case (r_state)
            bss_pkg::S_IDLE: begin
                n_j    = '0;
                n_pass = '0;
                n_hit  = 1'b0;
                n_pos  = '0;
                n_key  = in_val;
                if (in_acc && (s_axis_tuser == bss_pkg::REQ_LOAD)) begin
                    // Store the word if there is room, else flag the drop.
                    mem_we    = has_room;
                    mem_wa    = AW'(cnt_base);
                    mem_wd    = in_val;
                    n_count   = load_cnt;
                    n_dropped = drop_base || !has_room;
                    n_closed  = s_axis_tlast;
                end
            end
            bss_pkg::S_PASS_START: begin
                mem_ra = '0;
            end
            bss_pkg::S_PASS_FIRST: begin
                // First element of the pass becomes the carried value.
                n_carry = r_rd_data;
                mem_ra  = AW'(1);
                n_j     = AW'(1);
            end
            bss_pkg::S_PASS_RUN: begin
                // Keep the larger value moving up, write the smaller one back.
                mem_we  = 1'b1;
                mem_wa  = r_j - AW'(1);
                mem_wd  = gt ? r_rd_data : r_carry;
                n_carry = gt ? r_carry : r_rd_data;
                mem_ra  = r_j + AW'(1);
                if (!run_end) begin
                    n_j = r_j + AW'(1);
                end
            end
            bss_pkg::S_PASS_END: begin
                mem_we = 1'b1;
                mem_wa = AW'(r_count - CW'(1));
                mem_wd = r_carry;
                n_j    = '0;
                n_pass = r_pass + AW'(1);
            end
            bss_pkg::S_EMIT_RD: begin
                mem_ra = r_j;
            end
            bss_pkg::S_EMIT_WAIT: begin
                mem_ra = r_j;
                if (out_free) begin
                    out_load  = 1'b1;
                    n_o_kind  = bss_pkg::KIND_SORTED;
                    n_o_value = bss_pkg::VAL_W'(r_rd_data);
                    n_o_index = bss_pkg::IDX_W'(r_j);
                    n_o_found = 1'b0;
                    n_o_ovf   = r_dropped;
                    n_o_last  = emit_end;
                    n_j       = r_j + AW'(1);
                end
            end
            bss_pkg::S_SRCH_RD: begin
                mem_ra = r_j;
            end
            bss_pkg::S_SRCH_CMP: begin
                if (key_hit) begin
                    n_hit = 1'b1;
                    n_pos = r_j;
                end else if (!run_end) begin
                    n_j = r_j + AW'(1);
                end
            end
            bss_pkg::S_ANSWER: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    n_o_kind  = bss_pkg::KIND_SEARCH;
                    n_o_value = '0;
                    n_o_index = r_hit ? bss_pkg::IDX_W'(r_pos) : '0;
                    n_o_found = r_hit;
                    n_o_ovf   = r_dropped;
                    n_o_last  = 1'b1;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
        n_out_valid = out_load || (r_out_valid && !m_axis_tready);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bss_pkg::S_IDLE;
            r_count     <= '0;
            r_closed    <= 1'b1;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_closed    <= n_closed;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge i_clk) begin
        r_j     <= n_j;
        r_pass  <= n_pass;
        r_carry <= n_carry;
        r_key   <= n_key;
        r_hit   <= n_hit;
        r_pos   <= n_pos;
        if (out_load) begin
            r_o_kind  <= n_o_kind;
            r_o_value <= n_o_value;
            r_o_index <= n_o_index;
            r_o_found <= n_o_found;
            r_o_ovf   <= n_o_ovf;
            r_o_last  <= n_o_last;
        end
    end

    // Element memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

    // Output stream.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {1'b0, r_o_ovf, r_o_found, r_o_index, r_o_value};

    // Shorthand terms for the checks below.
    assign close_acc  = in_acc && s_axis_tlast && (s_axis_tuser == bss_pkg::REQ_LOAD);
    assign srch_acc   = in_acc && (s_axis_tuser == bss_pkg::REQ_SEARCH);
    assign answer_out = m_axis_tvalid && (m_axis_tuser == bss_pkg::KIND_SEARCH);
    assign answer_ok  = m_axis_tlast && (m_axis_tdata[bss_pkg::VAL_W-1:0] == '0);
    assign count_ok   = (r_count <= CW'(DEPTH));

    // A closing load or a search always leaves the idle state.
    `BSS_ASSERT_NEXT(a_close_busy, i_clk, i_rst_n, close_acc, !s_axis_tready)
    `BSS_ASSERT_NEXT(a_search_busy, i_clk, i_rst_n, srch_acc, !s_axis_tready)
    // A search answer is a single word with a zero value.
    `BSS_ASSERT_NOW(a_answer_form, i_clk, i_rst_n, answer_out, answer_ok)
    // The fill count never passes the store depth.
    `BSS_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, count_ok)

endmodule

`default_nettype wire

@@ tb/bubble_sort_and_search_core_tb.sv @@
// Self-checking testbench for bubble_sort_and_search_core: streams load and search words,
// predicts every sorted run and search answer, and checks them in order on the output side.
// Depends on bss_pkg and the core RTL only.
`timescale 1ns / 100ps

module bubble_sort_and_search_core_tb;

    localparam int HOLD_CYCLES  = 2000;
    localparam int DRAIN_CYCLES = 200;
    localparam int PHASE_WORDS  = 120;

    // One output word, split into its fields.
    typedef struct {
        logic                             kind;
        logic signed [bss_pkg::VAL_W-1:0] val;
        logic [bss_pkg::IDX_W-1:0]        idx;
        logic                             found;
        logic                             overflow;
        logic                             pad;
        logic                             last;
    } t_sort_result;

    // Mirror of the core's element store, plus the queue of results still owed.
    class t_sort_scoreboard;
        logic signed [bss_pkg::VAL_W-1:0] elems [bss_pkg::DEPTH_DEF];
        int unsigned             fill = 0;
        bit                      closed = 1'b1;
        bit                      dropped = 1'b0;
        t_sort_result            pending [$];
        int errors = 0;
        int words_in = 0;
        int words_out = 0;
        int sets_sorted = 0;
        int searches = 0;
        int hits = 0;
        int overflowed_sets = 0;

        function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected 0x%08h, actual 0x%08h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Update the mirror with one accepted input word and queue what it causes.
        function void note_input(logic req, logic signed [bss_pkg::VAL_W-1:0] v, logic lst);
            t_sort_result                     r;
            int unsigned                      i;
            int unsigned                      j;
            logic signed [bss_pkg::VAL_W-1:0] t;
            words_in++;
            r.found    = 1'b0;
            r.idx      = '0;
            r.val      = '0;
            r.pad      = 1'b0;
            r.overflow = dropped;
            if (req == bss_pkg::REQ_SEARCH) begin
                // First match in store order, whether the set is sorted or still open.
                searches++;
                r.kind = bss_pkg::KIND_SEARCH;
                r.last = 1'b1;
                for (i = 0; i < fill; i++) begin
                    if (elems[i] == v) begin
                        r.found = 1'b1;
                        r.idx   = bss_pkg::IDX_W'(i);
                        break;
                    end
                end
                if (r.found) hits++;
                pending.push_back(r);
                return;
            end
            // A load after a closed set starts a fresh one.
            if (closed) begin
                fill    = 0;
                dropped = 1'b0;
                closed  = 1'b0;
            end
            if (fill < bss_pkg::DEPTH_DEF) begin
                elems[fill] = v;
                fill++;
            end else begin
                dropped = 1'b1;
            end
            if (!lst) return;
            // Closing load: full passes, swap only on strictly greater.
            closed = 1'b1;
            sets_sorted++;
            if (dropped) overflowed_sets++;
            for (i = 0; i < fill; i++) begin
                for (j = 0; j + 1 < fill; j++) begin
                    if (elems[j] > elems[j + 1]) begin
                        t            = elems[j];
                        elems[j]     = elems[j + 1];
                        elems[j + 1] = t;
                    end
                end
            end
            for (i = 0; i < fill; i++) begin
                r.kind     = bss_pkg::KIND_SORTED;
                r.val      = elems[i];
                r.idx      = bss_pkg::IDX_W'(i);
                r.found    = 1'b0;
                r.overflow = dropped;
                r.last     = (i + 1 == fill);
                pending.push_back(r);
            end
        endfunction

        // Compare one output word with the oldest expected one.
        function void check_result(t_sort_result got);
            t_sort_result want;
            words_out++;
            if (pending.size() == 0) begin
                $error("unexpected result word: kind %0d value 0x%08h index %0d",
                       got.kind, got.val, got.idx);
                errors++;
                return;
            end
            want = pending.pop_front();
            cmp_field("kind", want.kind, got.kind);
            cmp_field("value_res", want.val, got.val);
            cmp_field("index", want.idx, got.idx);
            cmp_field("found", want.found, got.found);
            cmp_field("overflow", want.overflow, got.overflow);
            cmp_field("pad", want.pad, got.pad);
            cmp_field("last_res", want.last, got.last);
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [bss_pkg::VAL_W-1:0]       s_axis_tdata = '0;
    logic                            s_axis_tuser = bss_pkg::REQ_LOAD;
    logic                            s_axis_tlast = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [bss_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;
    logic                            m_axis_tlast;

    int idle_pct = 0;
    int stall_pct = 0;
    bit hold_go = 1'b0;
    int hold_count = 0;

    t_sort_scoreboard sb = new();

    bubble_sort_and_search_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Output side: one long hold-off when asked, otherwise random stalls.
    always @(posedge i_clk) begin
        if (hold_go && hold_count < HOLD_CYCLES) begin
            hold_count    <= hold_count + 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Every accepted output word goes to the scoreboard.
    always @(posedge i_clk) begin
        t_sort_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind     = m_axis_tuser;
            got.val      = m_axis_tdata[31:0];
            got.idx      = m_axis_tdata[36:32];
            got.found    = m_axis_tdata[37];
            got.overflow = m_axis_tdata[38];
            got.pad      = m_axis_tdata[39];
            got.last     = m_axis_tlast;
            sb.check_result(got);
        end
    end

    // Offer one word, with random idle cycles before it, and wait until it is taken.
    // Valid is only lowered on an idle gap, so back-to-back words keep it high.
    task automatic send_word(logic req, logic [bss_pkg::VAL_W-1:0] v, logic lst);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= req;
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(req, v, lst);
    endtask

    // Values drawn from a narrow pool, the extremes, or the full range.
    function automatic logic [bss_pkg::VAL_W-1:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom_range(8) - 4;
            1: begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Search keys: half from the current store, so hits are common.
    function automatic logic [bss_pkg::VAL_W-1:0] search_key();
        if (sb.fill > 0 && $urandom_range(1) == 1)
            return sb.elems[$urandom_range(sb.fill - 1)];
        return rand_value();
    endfunction

    // One set of loads, mostly small, now and then full or overflowing, with
    // searches mixed in while it is open and after it is sorted.
    task automatic random_set();
        int pick;
        int n;
        int k;
        pick = $urandom_range(99);
        if (pick < 70)      n = $urandom_range(6, 1);
        else if (pick < 90) n = $urandom_range(31, 7);
        else if (pick < 96) n = bss_pkg::DEPTH_DEF;
        else                n = $urandom_range(bss_pkg::DEPTH_DEF + 3, bss_pkg::DEPTH_DEF + 1);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0)
                send_word(bss_pkg::REQ_SEARCH, search_key(), 1'($urandom_range(1)));
            send_word(bss_pkg::REQ_LOAD, rand_value(), k == n - 1);
        end
        repeat ($urandom_range(3))
            send_word(bss_pkg::REQ_SEARCH, search_key(), 1'($urandom_range(1)));
    endtask

    initial begin
        int ph;
        int goal;
        int k;
        int idle_sched [4];
        int stall_sched [4];
        idle_sched  = '{0, 72, 0, 36};
        stall_sched = '{0, 0, 72, 36};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: search on an empty store, extremes and duplicates in one set.
        send_word(bss_pkg::REQ_SEARCH, 32'h0000_0000, 1'b0);
        send_word(bss_pkg::REQ_LOAD, 32'h7FFF_FFFF, 1'b0);
        send_word(bss_pkg::REQ_LOAD, 32'h8000_0000, 1'b0);
        send_word(bss_pkg::REQ_LOAD, 32'h0000_0000, 1'b0);
        send_word(bss_pkg::REQ_LOAD, 32'hFFFF_FFFF, 1'b0);
        send_word(bss_pkg::REQ_LOAD, 32'hFFFF_FFFF, 1'b0);
        send_word(bss_pkg::REQ_LOAD, 32'h0000_0001, 1'b1);
        send_word(bss_pkg::REQ_SEARCH, 32'hFFFF_FFFF, 1'b0);
        send_word(bss_pkg::REQ_SEARCH, 32'h0000_0005, 1'b1);
        send_word(bss_pkg::REQ_SEARCH, 32'h7FFF_FFFF, 1'b0);
        // A set of one element.
        send_word(bss_pkg::REQ_LOAD, 32'd42, 1'b1);
        send_word(bss_pkg::REQ_SEARCH, 32'd42, 1'b0);
        // Searching an open set sees the load order; old contents are gone.
        send_word(bss_pkg::REQ_LOAD, 32'd3, 1'b0);
        send_word(bss_pkg::REQ_LOAD, 32'd9, 1'b0);
        send_word(bss_pkg::REQ_SEARCH, 32'd9, 1'b0);
        send_word(bss_pkg::REQ_SEARCH, 32'd42, 1'b1);
        send_word(bss_pkg::REQ_LOAD, 32'd1, 1'b1);
        send_word(bss_pkg::REQ_SEARCH, 32'd1, 1'b1);
        // Strictly descending input.
        send_word(bss_pkg::REQ_LOAD, 32'd5, 1'b0);
        send_word(bss_pkg::REQ_LOAD, 32'd4, 1'b0);
        send_word(bss_pkg::REQ_LOAD, 32'd3, 1'b0);
        send_word(bss_pkg::REQ_LOAD, 32'd2, 1'b1);

        // Backpressure: the sink holds off while a full set plus two dropped loads
        // goes in, so the core sorts, blocks on output and refuses the searches.
        hold_go <= 1'b1;
        for (k = 0; k < bss_pkg::DEPTH_DEF + 2; k++)
            send_word(bss_pkg::REQ_LOAD, rand_value(), k == bss_pkg::DEPTH_DEF + 1);
        send_word(bss_pkg::REQ_SEARCH, search_key(), 1'b0);
        send_word(bss_pkg::REQ_SEARCH, rand_value(), 1'b1);
        send_word(bss_pkg::REQ_SEARCH, search_key(), 1'b0);

        // Random sets under each idle and stall mix.
        for (ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_sched[ph];
            stall_pct <= stall_sched[ph];
            goal = sb.words_in + PHASE_WORDS;
            while (sb.words_in < goal) random_set();
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d input words and %0d output words: %0d sorted sets",
                 sb.words_in, sb.words_out, sb.sets_sorted);
        $display("(%0d with dropped loads) and %0d searches, %0d of them hits.",
                 sb.overflowed_sets, sb.searches, sb.hits);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog for a hung core.
    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
